// ----- rtl/rptk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptk_pkg
// Types, codes and the per-event role update shared by the role tracker.
// ----------------------------------------------------------------------------
package rptk_pkg;

    localparam int COST_BYTES = 22;
    localparam int COST_W     = COST_BYTES * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIDGING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd1;
    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 32'd6;

    localparam logic [7:0] FL_ROOT    = 8'h78;
    localparam logic [7:0] FL_ROOT_TC = 8'h79;
    localparam logic [7:0] FL_ALT     = 8'h44;
    localparam logic [7:0] FL_ALT_TC  = 8'h45;
    localparam int         PROPOSAL_BIT = 1;

    localparam logic [1:0] R_UNKNOWN = 2'd0;
    localparam logic [1:0] R_ALT     = 2'd1;
    localparam logic [1:0] R_ROOT    = 2'd2;

    localparam logic [1:0] EV_BETTER = 2'd0;
    localparam logic [1:0] EV_EQUAL  = 2'd1;
    localparam logic [1:0] EV_WORSE  = 2'd2;
    localparam logic [1:0] EV_DOWN   = 2'd3;

    localparam logic OP_BPDU = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic        lan;
        logic [7:0]  rx_flags;
        logic [47:0] cost_top;
        logic [63:0] cost_mid;
        logic [63:0] cost_low;
    } in_item_t;

    typedef struct packed {
        logic       tx_lan;
        logic [7:0] tx_flags;
        logic       last;
    } out_item_t;

    // transmit request from one processed item: n copies of (lan, flags)
    typedef struct packed {
        logic [1:0] n;
        logic       lan;
        logic [7:0] flags;
    } res_t;

    typedef struct packed {
        logic [1:0][1:0] role;
        logic [1:0]      tc;
        logic [1:0]      n;
        logic [7:0]      flags;
    } step_t;

    // One event on port p against the current roles of both ports.
    function automatic step_t role_step(input logic [1:0] ev, input logic p,
                                        input logic quiet,
                                        input logic [1:0][1:0] role,
                                        input logic [1:0] tc);
        step_t      s;
        logic       q;
        logic [1:0] rp;
        logic [1:0] rq;
        logic       bpdu;
        q    = ~p;
        rp   = role[p];
        rq   = role[q];
        bpdu = (ev != EV_DOWN);
        s.role  = role;
        s.tc    = tc;
        s.n     = 2'd0;
        s.flags = FL_ROOT;
        if (rp == R_UNKNOWN && rq == R_UNKNOWN)
        begin
            if (bpdu)
            begin
                s.tc[p]   = 1'b0;
                s.role[p] = R_ROOT;
                s.n       = 2'd2;
                s.flags   = FL_ROOT_TC;
            end
        end
        else if (rp == R_ROOT && (rq == R_UNKNOWN || rq == R_ALT))
        begin
            if (!bpdu)
            begin
                s.tc[p]   = 1'b0;
                s.role[p] = R_UNKNOWN;
                if (rq == R_ALT)
                begin
                    s.role[q] = R_ROOT;
                    s.tc[q]   = 1'b1;
                end
            end
            else if (tc[p])
            begin
                s.tc[p] = 1'b0;
                s.n     = 2'd2;
                s.flags = FL_ROOT_TC;
            end
            else if (!quiet)
            begin
                s.n     = 2'd1;
                s.flags = FL_ROOT;
            end
        end
        else if (rp == R_UNKNOWN && rq == R_ROOT)
        begin
            if (ev == EV_BETTER)
            begin
                s.tc[p]   = 1'b0;
                s.tc[q]   = 1'b1;
                s.role[p] = R_ROOT;
                s.role[q] = R_ALT;
                s.n       = 2'd2;
                s.flags   = FL_ROOT_TC;
            end
            else if (bpdu)
            begin
                s.tc[p]   = 1'b0;
                s.role[p] = R_ALT;
                s.n       = 2'd2;
                s.flags   = FL_ALT_TC;
            end
        end
        else if (rp == R_ALT && rq == R_ROOT)
        begin
            if (!bpdu)
            begin
                s.tc[p]   = 1'b0;
                s.role[p] = R_UNKNOWN;
            end
            else if (ev == EV_BETTER)
            begin
                s.tc[p]   = 1'b0;
                s.tc[q]   = 1'b1;
                s.role[p] = R_ROOT;
                s.role[q] = R_ALT;
                s.n       = 2'd2;
                s.flags   = FL_ROOT_TC;
            end
            else if (tc[p])
            begin
                s.tc[p] = 1'b0;
                s.n     = 2'd2;
                s.flags = FL_ALT_TC;
            end
            else if (!quiet)
            begin
                s.n     = 2'd1;
                s.flags = FL_ALT;
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/rptk_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptk_fsm
// Role state, stored cost vector, silence timers and configuration registers.
// Processes one registered item per fire and reports its transmit request.
// ----------------------------------------------------------------------------
module rptk_fsm #(
    parameter int TIMER_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  rptk_pkg::in_item_t                  item,
    input  logic                                wr_en,
    input  logic [rptk_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [rptk_pkg::CFG_DATA_W-1:0]     wr_data,
    output rptk_pkg::res_t                      res
);
    import rptk_pkg::*;

    localparam int CW = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

    logic                    bridging_reg;
    logic [CFG_DATA_W-1:0]   timeout_reg;
    logic [1:0][1:0]         role_reg, role_next;
    logic [1:0]              tc_reg, tc_next;
    logic [COST_W-1:0]       cost_reg;
    logic [TIMER_WIDTH-1:0]  sil_a_reg, sil_a_next;
    logic [TIMER_WIDTH-1:0]  sil_b_reg, sil_b_next;

    logic [COST_W-1:0]       cost_new;
    logic [1:0]              ev;
    logic                    quiet;
    logic                    down_a, down_b;
    step_t                   s_bpdu, s_da, s_db_in, s_db;
    logic [TIMER_WIDTH-1:0]  inc_a, inc_b;

    assign cost_new = {item.cost_top, item.cost_mid, item.cost_low};

    always_comb
    begin
        if (cost_reg == cost_new)
            ev = EV_EQUAL;
        else if (cost_reg > cost_new)
            ev = EV_BETTER;
        else
            ev = EV_WORSE;
    end

    assign quiet  = (ev == EV_EQUAL) && !item.rx_flags[PROPOSAL_BIT];
    assign s_bpdu = role_step(ev, item.lan, quiet, role_reg, tc_reg);

    // saturating silence timers
    assign inc_a = (sil_a_reg == {TIMER_WIDTH{1'b1}}) ? sil_a_reg : sil_a_reg + 1'b1;
    assign inc_b = (sil_b_reg == {TIMER_WIDTH{1'b1}}) ? sil_b_reg : sil_b_reg + 1'b1;

    assign down_a = bridging_reg && (CW'(inc_a) > CW'(timeout_reg));
    assign down_b = bridging_reg && (CW'(inc_b) > CW'(timeout_reg));

    // link-down for A is applied before B
    assign s_da = role_step(EV_DOWN, 1'b0, 1'b0, role_reg, tc_reg);

    always_comb
    begin
        s_db_in = s_da;
        if (!down_a)
        begin
            s_db_in.role = role_reg;
            s_db_in.tc   = tc_reg;
        end
    end

    assign s_db = role_step(EV_DOWN, 1'b1, 1'b0, s_db_in.role, s_db_in.tc);

    always_comb
    begin
        role_next  = role_reg;
        tc_next    = tc_reg;
        sil_a_next = sil_a_reg;
        sil_b_next = sil_b_reg;
        res.n      = 2'd0;
        res.lan    = item.lan;
        res.flags  = s_bpdu.flags;
        if (item.opcode == OP_TICK)
        begin
            sil_a_next = inc_a;
            sil_b_next = inc_b;
            if (down_b)
            begin
                role_next = s_db.role;
                tc_next   = s_db.tc;
            end
            else
            begin
                role_next = s_db_in.role;
                tc_next   = s_db_in.tc;
            end
        end
        else
        begin
            if (item.lan)
                sil_b_next = '0;
            else
                sil_a_next = '0;
            if (bridging_reg)
            begin
                role_next = s_bpdu.role;
                tc_next   = s_bpdu.tc;
                res.n     = s_bpdu.n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridging_reg <= 1'b1;
            timeout_reg  <= TIMEOUT_RST;
            role_reg     <= {R_UNKNOWN, R_UNKNOWN};
            tc_reg       <= '0;
            cost_reg     <= '1;
            sil_a_reg    <= '0;
            sil_b_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_BRIDGING: bridging_reg <= wr_data[0];
                    CFG_TIMEOUT:  timeout_reg  <= wr_data;
                    default:      ;
                endcase
            end
            if (fire)
            begin
                role_reg  <= role_next;
                tc_reg    <= tc_next;
                sil_a_reg <= sil_a_next;
                sil_b_reg <= sil_b_next;
                if (item.opcode == OP_BPDU && bridging_reg)
                    cost_reg <= cost_new;
            end
        end
    end

endmodule

// ----- rtl/rptk_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptk_outq
// Two-entry result queue; takes a whole request (zero to two items) at once.
// ----------------------------------------------------------------------------
module rptk_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rptk_pkg::res_t          res,
    output logic                    can_take,
    output logic                    result_valid,
    input  logic                    result_stall,
    output rptk_pkg::out_item_t     result
);
    import rptk_pkg::*;

    out_item_t  q0_reg, q1_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && !result_stall;
    // a new request goes in only when the queue is empty or its last entry leaves this cycle
    assign can_take     = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);
    assign result       = q0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (push && can_take)
            count_reg <= res.n;
        else if (pop)
            count_reg <= count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push && can_take)
        begin
            q0_reg.tx_lan   <= res.lan;
            q0_reg.tx_flags <= res.flags;
            q0_reg.last     <= (res.n != 2'd2);
            q1_reg.tx_lan   <= res.lan;
            q1_reg.tx_flags <= res.flags;
            q1_reg.last     <= 1'b1;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

endmodule

// ----- rtl/dual_port_rstp_role_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_port_rstp_role_tracker
// RSTP role tracking for two redundant LAN ports with BPDU transmit requests.
//
// Input channel item/item_valid/item_stall carries a received BPDU (cost
// vector, flags, port) or a time tick. Output channel result/result_valid/
// result_stall gives zero, one or two transmit requests per item; last marks
// the final one of an item. Configuration is a plain write port (wr_en,
// wr_index, wr_data); the user must write it only while the block is idle,
// which the block itself does not enforce. An accepted item lands in an input
// register; the role update runs on it once the result queue can take its
// requests, and they enter the two-entry result queue at that edge.
// Items with no request retire at one per cycle while the result queue is
// empty; an item with two requests holds back the next item until its second
// request leaves, as the result queue has a single drain port.
// Reset leaves roles unknown, timers cleared, the stored cost all ones,
// bridging enabled and timeout 6. A stalled result holds, the queue fills and
// item_stall rises while the registered item waits for queue space.
// ----------------------------------------------------------------------------
module dual_port_rstp_role_tracker #(
    parameter int TIMER_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  rptk_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rptk_pkg::out_item_t                 result,
    input  logic                                wr_en,
    input  logic [rptk_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [rptk_pkg::CFG_DATA_W-1:0]     wr_data
);
    import rptk_pkg::*;

    in_item_t item_reg;
    logic     valid_reg;
    logic     can_take;
    logic     fire;
    logic     accept;
    res_t     res;

    assign fire       = valid_reg && can_take;
    assign item_stall = valid_reg && !can_take;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (fire)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    rptk_fsm #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .res      (res)
    );

    rptk_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fire),
        .res          (res),
        .can_take     (can_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- sim/tb_dual_port_rstp_role_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_port_rstp_role_tracker
// Self-checking bench for the two-port RSTP role tracker.
//
// A behavioral copy of the role machine, cost compare and silence timers runs
// beside the block. It is updated on every accepted item and every register
// write, and it queues the transmit requests that the item must produce. A
// checker pops one request per accepted result and compares it field by field.
// Directed walks cover every role transition, the quiet rule, bridging off and
// the timeout extremes. Random phases with varied settings follow. Both sides
// idle at random, and one long receiver hold makes the input back up.
// ----------------------------------------------------------------------------
module tb_dual_port_rstp_role_tracker;

    import rptk_pkg::*;

    localparam int DRAIN_CYCLES = 6;

    typedef enum int {SH_EQUAL, SH_BETTER, SH_WORSE, SH_RANDOM} cost_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    in_item_t              item;
    logic                  result_valid;
    logic                  result_stall;
    out_item_t             result;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    // shadow of the block state
    logic                  cfg_bridging;
    logic [31:0]           cfg_timeout;
    logic [1:0]            port_role [2];
    logic                  tc_due [2];
    logic [31:0]           silence [2];
    logic [COST_W-1:0]     cost_seen;

    out_item_t             tx_expected [$];
    int                    fail_count;
    int                    long_hold;
    bit                    no_idle;

    dual_port_rstp_role_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic reset_shadow();
        cfg_bridging = 1'b1;
        cfg_timeout  = TIMEOUT_RST;
        for (int i = 0; i < 2; i++)
        begin
            port_role[i] = R_UNKNOWN;
            tc_due[i]    = 1'b0;
            silence[i]   = '0;
        end
        cost_seen = '1;
    endtask

    task automatic push_tx(input logic p, input logic [7:0] flags, input int times);
        out_item_t r;
        for (int k = 0; k < times; k++)
        begin
            r.tx_lan   = p;
            r.tx_flags = flags;
            r.last     = (k == times - 1);
            tx_expected.push_back(r);
        end
    endtask

    // port p wins root, the other port falls back to alternate with TC owed
    task automatic take_root(input logic p);
        tc_due[p]     = 1'b0;
        tc_due[~p]    = 1'b1;
        port_role[p]  = R_ROOT;
        port_role[~p] = R_ALT;
        push_tx(p, FL_ROOT_TC, 2);
    endtask

    task automatic apply_event(input logic [1:0] ev, input logic p, input logic [7:0] flags);
        logic       q;
        logic [1:0] rp;
        logic [1:0] rq;
        logic       bpdu;
        logic       quiet;
        q     = ~p;
        rp    = port_role[p];
        rq    = port_role[q];
        bpdu  = (ev != EV_DOWN);
        quiet = (ev == EV_EQUAL) && !flags[PROPOSAL_BIT];
        unique case ({rp, rq})
            {R_UNKNOWN, R_UNKNOWN}:
                if (bpdu)
                begin
                    tc_due[p]    = 1'b0;
                    port_role[p] = R_ROOT;
                    push_tx(p, FL_ROOT_TC, 2);
                end
            {R_ROOT, R_UNKNOWN}, {R_ROOT, R_ALT}:
                if (!bpdu)
                begin
                    tc_due[p]    = 1'b0;
                    port_role[p] = R_UNKNOWN;
                    if (rq == R_ALT)
                    begin
                        port_role[q] = R_ROOT;
                        tc_due[q]    = 1'b1;
                    end
                end
                else if (tc_due[p])
                begin
                    tc_due[p] = 1'b0;
                    push_tx(p, FL_ROOT_TC, 2);
                end
                else if (!quiet)
                    push_tx(p, FL_ROOT, 1);
            {R_UNKNOWN, R_ROOT}:
                if (ev == EV_BETTER)
                    take_root(p);
                else if (bpdu)
                begin
                    tc_due[p]    = 1'b0;
                    port_role[p] = R_ALT;
                    push_tx(p, FL_ALT_TC, 2);
                end
            {R_ALT, R_ROOT}:
                if (!bpdu)
                begin
                    tc_due[p]    = 1'b0;
                    port_role[p] = R_UNKNOWN;
                end
                else if (ev == EV_BETTER)
                    take_root(p);
                else if (tc_due[p])
                begin
                    tc_due[p] = 1'b0;
                    push_tx(p, FL_ALT_TC, 2);
                end
                else if (!quiet)
                    push_tx(p, FL_ALT, 1);
            default:
                ;
        endcase
    endtask

    task automatic predict_tx_requests(input in_item_t it);
        logic [COST_W-1:0] incoming;
        logic [1:0]        ev;
        if (it.opcode == OP_TICK)
        begin
            for (int i = 0; i < 2; i++)
                if (silence[i] != '1)
                    silence[i]++;
            if (cfg_bridging)
            begin
                // A is handled first, B sees the roles that A left behind
                if (silence[0] > cfg_timeout)
                    apply_event(EV_DOWN, 1'b0, 8'h00);
                if (silence[1] > cfg_timeout)
                    apply_event(EV_DOWN, 1'b1, 8'h00);
            end
        end
        else
        begin
            silence[it.lan] = '0;
            if (cfg_bridging)
            begin
                incoming = {it.cost_top, it.cost_mid, it.cost_low};
                if (cost_seen > incoming)
                    ev = EV_BETTER;
                else if (cost_seen == incoming)
                    ev = EV_EQUAL;
                else
                    ev = EV_WORSE;
                cost_seen = incoming;
                apply_event(ev, it.lan, it.rx_flags);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    function automatic in_item_t bpdu(input logic lan, input logic [7:0] flags,
                                      input logic [47:0] top, input logic [63:0] mid,
                                      input logic [63:0] low);
        in_item_t it;
        it.opcode   = OP_BPDU;
        it.lan      = lan;
        it.rx_flags = flags;
        it.cost_top = top;
        it.cost_mid = mid;
        it.cost_low = low;
        return it;
    endfunction

    function automatic in_item_t tick_item();
        in_item_t it;
        it          = bpdu(1'($urandom), 8'($urandom), 48'({$urandom, $urandom}),
                           {$urandom, $urandom}, {$urandom, $urandom});
        it.opcode   = OP_TICK;
        return it;
    endfunction

    // new vector shaped against the last stored one
    function automatic in_item_t shaped_bpdu(input logic lan, input cost_shape_t shape);
        logic [COST_W-1:0] v;
        logic [COST_W-1:0] d;
        in_item_t          it;
        d = COST_W'($urandom_range(1, 1000)) << (32 * $urandom_range(0, 5));
        case (shape)
            SH_EQUAL:  v = cost_seen;
            SH_BETTER: v = (cost_seen > d) ? cost_seen - d : '0;
            SH_WORSE:  v = (~cost_seen > d) ? cost_seen + d : '1;
            default:   v = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        endcase
        it = bpdu(lan, 8'($urandom), '0, '0, '0);
        {it.cost_top, it.cost_mid, it.cost_low} = v;
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input int gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_tx_requests(it);
    endtask

    // sender pauses until every queued request is out and the pipe is empty
    task automatic drain_pending();
        item_valid <= 1'b0;
        while (tx_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_BRIDGING)
            cfg_bridging = val[0];
        else if (idx == CFG_TIMEOUT)
            cfg_timeout = val;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall, long hold on request
    // ------------------------------------------------------------------
    initial
    begin : rx_side
        int stall_left;
        int run_left;
        result_stall <= 1'b0;
        stall_left = 0;
        run_left   = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                stall_left = long_hold;
                long_hold  = 0;
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (no_idle || run_left > 0)
            begin
                result_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left = pick_gap();
                run_left   = $urandom_range(0, 12);
            end
        end
    end

    always @(posedge clk)
    begin : tx_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (tx_expected.size() == 0)
            begin
                $error("tx request with none pending: tx_lan %0d tx_flags %h last %0d",
                       result.tx_lan, result.tx_flags, result.last);
                fail_count++;
            end
            else
            begin
                want = tx_expected.pop_front();
                if (result.tx_lan !== want.tx_lan)
                begin
                    $error("tx_lan expected %0d actual %0d", want.tx_lan, result.tx_lan);
                    fail_count++;
                end
                if (result.tx_flags !== want.tx_flags)
                begin
                    $error("tx_flags expected %h actual %h", want.tx_flags, result.tx_flags);
                    fail_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_role_walk();
        // first BPDU equal to the reset vector, then every role pair in turn
        send_item(bpdu(1'b0, 8'h00, '1, '1, '1), pick_gap());        // A unknown -> root
        send_item(bpdu(1'b1, 8'hFF, '1, '1, '1), pick_gap());        // B unknown -> alt
        send_item(bpdu(1'b0, 8'h00, '1, '1, '1), pick_gap());        // root, equal, quiet
        send_item(bpdu(1'b0, 8'h02, '1, '1, '1), pick_gap());        // root, proposal
        send_item(bpdu(1'b1, 8'hFD, '1, '1, '1), pick_gap());        // alt, equal, quiet
        send_item(bpdu(1'b1, 8'h00, '0, '0, '0), pick_gap());        // alt wins root
        send_item(bpdu(1'b0, 8'h00, '0, '0, '0), pick_gap());        // TC beats quiet
        send_item(bpdu(1'b0, 8'h00, '0, '0, 64'h1), pick_gap());     // alt, worse
        send_item(bpdu(1'b0, 8'h55, '1, '0, '0), pick_gap());
        send_item(bpdu(1'b1, 8'hAA, '0, '1, '1), pick_gap());        // root, better
        send_item(bpdu(1'b0, 8'h00, '0, '0, '0), pick_gap());        // alt wins root
        send_item(bpdu(1'b1, 8'h00, '0, '0, '0), pick_gap());        // alt owes TC
        // silence past the timeout: A drops, B takes over, then B drops too
        repeat (8)
            send_item(tick_item(), pick_gap());
    endtask

    task automatic test_bridging_off();
        drain_pending();
        write_reg(CFG_BRIDGING, 32'hFFFF_FFFE);
        send_item(bpdu(1'b0, 8'hFF, '0, '0, '0), pick_gap());
        send_item(bpdu(1'b1, 8'h02, '1, '1, '0), pick_gap());
        repeat (10)
            send_item(tick_item(), pick_gap());
        drain_pending();
        write_reg(CFG_BRIDGING, 32'h0000_0001);
        send_item(bpdu(1'b0, 8'h00, 48'h0, 64'h0, 64'h5), pick_gap());
        send_item(bpdu(1'b1, 8'h02, 48'h0, 64'h0, 64'h5), pick_gap());
    endtask

    task automatic test_timeout_limits();
        drain_pending();
        write_reg(CFG_TIMEOUT, 32'h0);
        send_item(bpdu(1'b0, 8'h02, 48'h1, 64'h0, 64'h0), pick_gap());
        send_item(tick_item(), pick_gap());
        send_item(tick_item(), pick_gap());
        drain_pending();
        write_reg(CFG_TIMEOUT, 32'h1);
        send_item(bpdu(1'b0, 8'h00, 48'h2, 64'h0, 64'h0), pick_gap());
        send_item(bpdu(1'b1, 8'h00, 48'h1, 64'h0, 64'h0), pick_gap());
        repeat (3)
            send_item(tick_item(), pick_gap());
        drain_pending();
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        send_item(bpdu(1'b1, 8'h00, 48'h0, 64'h0, 64'h0), pick_gap());
        repeat (12)
            send_item(tick_item(), pick_gap());
        drain_pending();
        write_reg(CFG_TIMEOUT, TIMEOUT_RST);
    endtask

    task automatic test_backpressure();
        logic p;
        drain_pending();
        p = (port_role[1] == R_ROOT);
        long_hold = 80;
        // every BPDU on the root port asks for at least one request
        repeat (14)
            send_item(shaped_bpdu(p, SH_WORSE), 0);
        drain_pending();
    endtask

    task automatic random_phase(input int count);
        int                tick_pct;
        int                lan_b_pct;
        int                r;
        logic [31:0]       tmo;
        logic              lan;
        drain_pending();
        r = $urandom_range(0, 9);
        case (r)
            0:       tmo = 32'h0;
            1:       tmo = 32'hFFFF_FFFF;
            2:       tmo = $urandom;
            default: tmo = $urandom_range(1, 8);
        endcase
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_BRIDGING, {31'($urandom), ($urandom_range(0, 99) < 85)});
        no_idle   = ($urandom_range(0, 4) == 0);
        tick_pct  = $urandom_range(15, 45);
        lan_b_pct = $urandom_range(5, 95);
        repeat (count)
        begin
            lan = ($urandom_range(0, 99) < lan_b_pct);
            r   = $urandom_range(0, 99);
            if (r < tick_pct)
                send_item(tick_item(), pick_gap());
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_item(shaped_bpdu(lan, SH_EQUAL), pick_gap());
                else if (r < 60)
                    send_item(shaped_bpdu(lan, SH_BETTER), pick_gap());
                else if (r < 85)
                    send_item(shaped_bpdu(lan, SH_WORSE), pick_gap());
                else
                    send_item(shaped_bpdu(lan, SH_RANDOM), pick_gap());
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        repeat (11)
            random_phase(150);
    endtask

    initial
    begin
        fail_count = 0;
        long_hold  = 0;
        no_idle    = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        wr_en      <= 1'b0;
        wr_index   <= '0;
        wr_data    <= '0;
        reset_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_role_walk();
        test_bridging_off();
        test_timeout_limits();
        test_backpressure();
        test_random();
        drain_pending();

        if (fail_count == 0 && tx_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
